// ----- sv/ntw_pkg.sv -----
package ntw_pkg;

  localparam int VALUE_W         = 31;
  localparam int CODE_W          = 5;
  localparam int BCD_DIGITS      = 10;
  localparam int DD_STEPS        = 4;
  localparam int DD_STAGES       = (VALUE_W + DD_STEPS - 1) / DD_STEPS;
  localparam int NUM_GROUPS      = 4;
  localparam int SLOTS_PER_GROUP = 5;
  localparam int NUM_SLOTS       = NUM_GROUPS * SLOTS_PER_GROUP;
  localparam int SLOT_IDX_W      = $clog2(NUM_SLOTS);

  localparam logic [CODE_W-1:0] TENS_BASE     = 5'd18;
  localparam logic [CODE_W-1:0] WORD_TEN      = 5'd10;
  localparam logic [CODE_W-1:0] WORD_HUNDRED  = 5'd28;
  localparam logic [CODE_W-1:0] WORD_THOUSAND = 5'd29;
  localparam logic [CODE_W-1:0] WORD_MILLION  = 5'd30;
  localparam logic [CODE_W-1:0] WORD_BILLION  = 5'd31;

  typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    bcd_t               bcd;
    logic [VALUE_W-1:0] bin;
  } dd_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]             mask;
    logic [NUM_SLOTS-1:0][CODE_W-1:0] code;
  } slot_set_t;

endpackage

// ----- sv/ntw_digits.sv -----
module ntw_digits
  import ntw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output bcd_t               out_digits
);

  // one shift-and-add-3 iteration of the binary to BCD conversion
  function automatic dd_t dd_iter(dd_t d);
    dd_t r;
    r = d;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (r.bcd[k] >= 4'd5) begin
        r.bcd[k] = r.bcd[k] + 4'd3;
      end
    end
    r = dd_t'({r.bcd, r.bin} << 1);
    return r;
  endfunction

  logic [DD_STAGES-1:0] vld_r;
  dd_t                  dat_r   [DD_STAGES];
  dd_t                  dat_nxt [DD_STAGES];
  dd_t                  src     [DD_STAGES];
  logic [DD_STAGES-1:0] src_v;
  logic [DD_STAGES:0]   rdy;

  // a stage takes new data when it is empty or its content moves on
  always_comb begin
    rdy[DD_STAGES] = out_ready;
    for (int s = DD_STAGES - 1; s >= 0; s--) begin
      rdy[s] = !vld_r[s] || rdy[s+1];
    end
  end

  assign in_ready   = rdy[0];
  assign out_valid  = vld_r[DD_STAGES-1];
  assign out_digits = dat_r[DD_STAGES-1].bcd;

  for (genvar s = 0; s < DD_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign src[s]   = '{bcd: '0, bin: in_value};
      assign src_v[s] = in_valid;
    end else begin : g_rest
      assign src[s]   = dat_r[s-1];
      assign src_v[s] = vld_r[s-1];
    end

    always_comb begin
      dat_nxt[s] = src[s];
      for (int j = 0; j < DD_STEPS; j++) begin
        if (s * DD_STEPS + j < VALUE_W) begin
          dat_nxt[s] = dd_iter(dat_nxt[s]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_r[s] <= src_v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        dat_r[s] <= dat_nxt[s];
      end
    end
  end

endmodule

// ----- sv/number_to_word_tokens.sv -----
// Spells a 31-bit unsigned value as a run of English word codes.
// Input: a value transfers on a rising edge with start high and busy low.
// Output: one word per strobe; out_valid marks a cycle holding out_word_code
// and out_last_word, the latter set on the final word of each value. Results
// cannot be held off by the receiver.
// A value passes through 8 conversion stages, a slot stage, the word
// sequencer, then the output register; it waits in the slot stage while the
// sequencer still holds earlier words.
// Throughput: the word sequencer emits one word per cycle, and a value spells
// as 1 to 16 words. Words of consecutive values follow with no gap while the
// next value waits in the slot stage. Up to ten values are in flight: eight in the
// conversion stages, one in the slot stage and one in the sequencer; busy
// rises only when the stages and the slot stage are full behind the sequencer.
// Reset clears all valid bits and the sequencer; no word is strobed until a
// new value is taken.
module number_to_word_tokens
  import ntw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  output logic [CODE_W-1:0]  out_word_code,
  output logic               out_last_word
);

  function automatic slot_set_t build_slots(bcd_t d);
    slot_set_t                     r;
    logic [BCD_DIGITS+1:0][3:0]    dz;
    logic [3:0]                    h;
    logic [3:0]                    t;
    logic [3:0]                    u;
    logic                          nz;
    logic                          all_zero;
    int                            b;
    int                            i;
    dz       = {8'd0, d};
    all_zero = (d == '0);
    for (int g = 0; g < NUM_GROUPS; g++) begin
      b  = 3 * (NUM_GROUPS - 1 - g);
      i  = g * SLOTS_PER_GROUP;
      u  = dz[b];
      t  = dz[b+1];
      h  = dz[b+2];
      nz = (h != 4'd0) || (t != 4'd0) || (u != 4'd0);
      r.mask[i]   = (h != 4'd0);
      r.code[i]   = {1'b0, h};
      r.mask[i+1] = (h != 4'd0);
      r.code[i+1] = WORD_HUNDRED;
      r.mask[i+2] = (t >= 4'd2);
      r.code[i+2] = TENS_BASE + {1'b0, t};
      // teens take the units slot; zero spells only in the unit group
      r.mask[i+3] = (t == 4'd1) || (u != 4'd0) || (all_zero && g == NUM_GROUPS - 1);
      r.code[i+3] = (t == 4'd1) ? WORD_TEN + {1'b0, u} : {1'b0, u};
      r.mask[i+4] = nz && (g < NUM_GROUPS - 1);
      r.code[i+4] = CODE_W'(WORD_BILLION - g);
    end
    return r;
  endfunction

  logic      dig_valid;
  logic      dig_ready;
  bcd_t      dig_bcd;

  logic      slot_v_r;
  slot_set_t slot_r;
  logic      slot_rdy;

  logic [NUM_SLOTS-1:0]             em_mask_r;
  logic [NUM_SLOTS-1:0][CODE_W-1:0] em_code_r;
  logic [NUM_SLOTS-1:0]             em_rest;
  logic [SLOT_IDX_W-1:0]            em_sel;
  logic                             em_take;

  logic              out_valid_r;
  logic [CODE_W-1:0] out_word_code_r;
  logic              out_last_word_r;

  ntw_digits u_digits (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start),
    .in_ready   (dig_ready),
    .in_value   (in_value),
    .out_valid  (dig_valid),
    .out_ready  (slot_rdy),
    .out_digits (dig_bcd)
  );

  assign busy = !dig_ready;

  // pick the lowest pending slot; the sequencer frees on its final word
  always_comb begin
    em_sel  = '0;
    em_rest = em_mask_r;
    for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
      if (em_mask_r[k]) begin
        em_sel = SLOT_IDX_W'(k);
      end
    end
    em_rest[em_sel] = 1'b0;
    em_take         = (em_rest == '0);
  end

  assign slot_rdy = !slot_v_r || em_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_v_r    <= 1'b0;
      em_mask_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (slot_rdy) begin
        slot_v_r <= dig_valid;
      end
      if (em_take) begin
        em_mask_r <= slot_v_r ? slot_r.mask : '0;
      end else begin
        em_mask_r <= em_rest;
      end
      out_valid_r <= (em_mask_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (slot_rdy) begin
      slot_r <= build_slots(dig_bcd);
    end
    if (em_take) begin
      em_code_r <= slot_r.code;
    end
    out_word_code_r <= em_code_r[em_sel];
    out_last_word_r <= em_take;
  end

  assign out_valid     = out_valid_r;
  assign out_word_code = out_word_code_r;
  assign out_last_word = out_last_word_r;

endmodule

// ----- sim/ntw_word_checker.sv -----
module ntw_word_checker
  import ntw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_valid,
  input  logic [CODE_W-1:0]  out_word_code,
  input  logic               out_last_word,
  output int                 fail_count,
  output int                 pending,
  output int                 words_checked
);

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } word_t;

  word_t expected_words[$];

  int fail_total = 0;
  int words_seen = 0;
  int queued     = 0;

  assign fail_count    = fail_total;
  assign words_checked = words_seen;
  assign pending       = queued;

  function automatic void push_word(logic [CODE_W-1:0] code);
    word_t w;
    w.code = code;
    w.last = 1'b0;
    expected_words.push_back(w);
  endfunction

  // Split into billion/million/thousand/unit groups; zero groups give no words.
  function automatic void spell_value(logic [VALUE_W-1:0] value);
    int unsigned       rem;
    int unsigned       grp;
    int unsigned       rest;
    int unsigned       divisor[4];
    logic [CODE_W-1:0] scale_word[3];
    divisor    = '{1000000000, 1000000, 1000, 1};
    scale_word = '{WORD_BILLION, WORD_MILLION, WORD_THOUSAND};
    rem = int'(value);
    if (rem <= 19) begin
      push_word(CODE_W'(rem));
    end else begin
      for (int i = 0; i < 4; i++) begin
        grp = rem / divisor[i];
        rem = rem % divisor[i];
        if (grp != 0) begin
          rest = grp % 100;
          if (grp / 100 != 0) begin
            push_word(CODE_W'(grp / 100));
            push_word(WORD_HUNDRED);
          end
          if (rest >= 20) begin
            push_word(CODE_W'(TENS_BASE + rest / 10));
            rest = rest % 10;
          end
          if (rest != 0) begin
            push_word(CODE_W'(rest));
          end
          if (i < 3) begin
            push_word(scale_word[i]);
          end
        end
      end
    end
    expected_words[expected_words.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    word_t want;
    if (rst_n && start && !busy) begin
      spell_value(in_value);
    end
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $error("word transfer with nothing expected: code %0d last %0d",
               out_word_code, out_last_word);
        fail_total++;
      end else begin
        want = expected_words.pop_front();
        words_seen++;
        if (out_word_code !== want.code) begin
          $error("out_word_code mismatch: expected %0d, actual %0d",
                 want.code, out_word_code);
          fail_total++;
        end
        if (out_last_word !== want.last) begin
          $error("out_last_word mismatch: expected %0d, actual %0d",
                 want.last, out_last_word);
          fail_total++;
        end
      end
    end
    queued = expected_words.size();
  end

endmodule

// ----- sim/number_to_word_tokens_tb.sv -----
module number_to_word_tokens_tb;
  import ntw_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int NUM_RANDOM  = 385;
  localparam int CALM_TAIL   = 60;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic [CODE_W-1:0]  out_word_code;
  logic               out_last_word;

  int fail_count;
  int pending;
  int words_checked;
  int values_sent;
  int stall_cycles = 0;

  number_to_word_tokens i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_word_code (out_word_code),
    .out_last_word (out_last_word)
  );

  ntw_word_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_word_code (out_word_code),
    .out_last_word (out_last_word),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Any transfer on either side resets the stall count.
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("number_to_word_tokens_tb failed");
      $finish;
    end
  end

  task automatic send_value(logic [VALUE_W-1:0] v);
    start    <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
    values_sent++;
  endtask

  task automatic hold_off(int cycles);
    start    <= 1'b0;
    in_value <= VALUE_W'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Drop start and wait until every expected word has come out.
  task automatic drain_words();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    logic [VALUE_W-1:0] directed[$];
    longint             v;
    int unsigned        grp;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_value     = '0;
    values_sent  = 0;
    directed = '{0, 1, 7, 19, 20, 21, 99, 100, 101, 110, 119, 999, 1000, 1001,
                 12345, 100000, 1000000, 1000100, 1000010, 1000000000,
                 1000000001, 2000000000, 1777777777, 2147483647, 1070070017};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_value(directed[i]);
      if (i % 7 == 3) begin
        hold_off($urandom_range(1, 5));
      end
    end
    drain_words();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      case ($urandom_range(0, 5))
        0: v = $urandom_range(0, 19);
        1: v = $urandom_range(20, 999);
        2: v = {1'b0, $urandom} & 64'h7fff_ffff;
        default: begin
          // Compose from groups, often zero, to hit skipped groups and teens.
          v = $urandom_range(0, 2);
          for (int g = 0; g < 3; g++) begin
            case ($urandom_range(0, 3))
              0:       grp = 0;
              1:       grp = $urandom_range(1, 19);
              2:       grp = $urandom_range(1, 9) * 100 + $urandom_range(0, 19);
              default: grp = $urandom_range(0, 999);
            endcase
            v = v * 1000 + grp;
          end
          if (v > 64'd2147483647) begin
            v = v - 64'd1000000000;
          end
        end
      endcase
      send_value(VALUE_W'(v));
      if (n == NUM_RANDOM / 2) begin
        drain_words();
      end else if (n < NUM_RANDOM - CALM_TAIL && $urandom_range(0, 3) == 0) begin
        hold_off($urandom_range(1, 5));
      end
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    if (pending != 0) begin
      $error("%0d expected words never arrived", pending);
    end
    $display("Spelled %0d values into %0d checked word codes: zero, teens, tens,",
             values_sent, words_checked);
    $display("hundreds, skipped groups, every scale and the sixteen-word worst case.");
    if (fail_count == 0 && pending == 0) begin
      $display("number_to_word_tokens_tb passed");
    end else begin
      $display("number_to_word_tokens_tb failed");
    end
    $finish;
  end

endmodule
